@@ rtl/bba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int TOTAL_LOG2 = 16;
    localparam int MIN_LOG2   = 4;
    localparam int DEPTH      = TOTAL_LOG2 - MIN_LOG2;
    localparam int NODE_COUNT = (2 << DEPTH) - 1;
    localparam int ADDR_W     = DEPTH + 1;
    localparam int POS_W      = (DEPTH > 0) ? DEPTH : 1;
    localparam int LVL_W      = 4;
    localparam int K_W        = 5;
    localparam int OFF_W      = 16;
    localparam int SIZE_W     = 17;

    typedef enum logic [1:0] {
        NODE_ABSENT = 2'd0,
        NODE_FREE   = 2'd1,
        NODE_ALLOC  = 2'd2,
        NODE_SPLIT  = 2'd3
    } node_st_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FREE  = 2'd1,
        STAT_TOO_BIG  = 2'd2,
        STAT_UNKNOWN  = 2'd3
    } status_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     addr;
        node_st_t              wdata;
    } node_req_t;

    typedef struct packed {
        status_t               status;
        logic [OFF_W-1:0]      offset;
        logic [LVL_W-1:0]      level;
    } result_t;

    // heap-style index of node (level, position)
    function automatic logic [ADDR_W-1:0] node_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [POS_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        base = (ADDR_W'(1) << lvl) - ADDR_W'(1);
        return base + ADDR_W'(pos);
    endfunction

    // log2 of the size rounded up to a power of two; zero counts as one
    function automatic logic [K_W-1:0] size_log2(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] s1;
        logic [K_W-1:0]    k;
        s1 = (size == '0) ? '0 : size - SIZE_W'(1);
        k  = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (s1[i]) k = K_W'(i + 1);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

@@ rtl/buddy_block_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a 64 KiB pool with 16-byte minimum blocks.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 8191-entry node store before it takes
// the first word. Each request then runs on one node store port, with a
// registered read. An allocate scans each level from the target upwards,
// one node per read, and splits the first free node it finds down to the
// target level. A free walks the levels from the root down, skipping each
// level at which the offset is misaligned and reading the node where it is
// aligned, then releases the node, runs merge steps until a buddy check
// stops the merge or the root is reached, and hands over the result. One
// request is worked on at a time; the result sits in an output register so
// the next request is taken while it waits.
module buddy_block_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // req_size[16:0], block_offset[32:17], zero pad
    input  wire logic [0:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // granted_offset[15:0], granted_level[19:16], pad
    output logic [1:0]       m_tuser    // status
);
    import bba_pkg::*;

    logic      idle, done, out_free;
    result_t   result;
    node_req_t ram_req;
    node_st_t  ram_rd;
    logic      m_tvalid_reg;
    result_t   out_reg;

    assign s_tready = idle;
    assign out_free = !m_tvalid_reg || m_tready;

    bba_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_tvalid && idle),
        .mode         (s_tuser[0]),
        .req_size     (s_tdata[16:0]),
        .block_offset (s_tdata[32:17]),
        .idle         (idle),
        .out_free     (out_free),
        .done         (done),
        .result       (result),
        .ram_req      (ram_req),
        .ram_rd       (ram_rd)
    );

    bba_node_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (done) out_reg <= result;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'b0, out_reg.level, out_reg.offset};

endmodule
`default_nettype wire

@@ rtl/bba_node_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bba_node_ram
// Single-port node state store, one entry per tree node, registered read.
// ----------------------------------------------------------------------------
module bba_node_ram (
    input  wire logic              aclk,
    input  wire bba_pkg::node_req_t req,
    output bba_pkg::node_st_t      rd_data
);
    import bba_pkg::*;

    node_st_t mem [NODE_COUNT];
    node_st_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        rd_data_reg <= mem[req.addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/bba_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, free-block search, split, release and merge,
// all through the one node store port, with a shared shift unit.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic                         mode,
    input  wire logic [bba_pkg::SIZE_W-1:0]   req_size,
    input  wire logic [bba_pkg::OFF_W-1:0]    block_offset,
    output logic                              idle,
    input  wire logic                         out_free,
    output logic                              done,
    output bba_pkg::result_t                  result,
    output bba_pkg::node_req_t                ram_req,
    input  wire bba_pkg::node_st_t            ram_rd
);
    import bba_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_A_RD, S_A_CHK, S_SPLIT_P, S_SPLIT_L, S_SPLIT_R, S_A_GRANT,
        S_F_RD, S_F_CHK, S_F_REL,
        S_M_RD, S_M_CHK, S_M_A, S_M_B, S_M_UP,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  target_reg, target_next;
    logic [LVL_W-1:0]  orig_reg, orig_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    result_t           res_reg, res_next;

    logic [K_W-1:0]    k_req;
    logic [K_W-1:0]    blog;
    logic [OFF_W-1:0]  off_mask;
    logic              aligned;
    logic [POS_W-1:0]  off_pos;
    logic [POS_W-1:0]  last_pos;
    logic [POS_W-1:0]  buddy_pos;

    // shared shift unit: block size of the current level against the offset
    always_comb begin
        blog     = K_W'(TOTAL_LOG2) - K_W'(lvl_reg);
        off_mask = OFF_W'((17'd1 << blog) - 17'd1);
        aligned  = (off_reg & off_mask) == '0;
        off_pos  = POS_W'(off_reg >> blog);
        last_pos = POS_W'((13'd1 << lvl_reg) - 13'd1);
        buddy_pos = pos_reg ^ POS_W'(1);
        k_req    = size_log2(req_size);
        if (k_req < K_W'(MIN_LOG2)) k_req = K_W'(MIN_LOG2);
    end

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        lvl_next    = lvl_reg;
        target_next = target_reg;
        orig_next   = orig_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        off_next    = off_reg;
        res_next    = res_reg;
        ram_req.wr_en = 1'b0;
        ram_req.addr  = node_addr(lvl_reg, pos_reg);
        ram_req.wdata = NODE_FREE;

        unique case (state_reg)
            S_CLEAR: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = clr_reg;
                ram_req.wdata = (clr_reg == '0) ? NODE_FREE : NODE_ABSENT;
                clr_next      = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(NODE_COUNT - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    off_next = block_offset;
                    lvl_next = '0;
                    pos_next = '0;
                    if (mode) begin
                        state_next = S_F_RD;
                    end else if (k_req > K_W'(TOTAL_LOG2)) begin
                        res_next   = '{status: STAT_TOO_BIG, offset: '0, level: '0};
                        state_next = S_RESP;
                    end else begin
                        k_next      = k_req;
                        target_next = LVL_W'(K_W'(TOTAL_LOG2) - k_req);
                        lvl_next    = LVL_W'(K_W'(TOTAL_LOG2) - k_req);
                        state_next  = S_A_RD;
                    end
                end
            end
            S_A_RD: state_next = S_A_CHK;
            S_A_CHK: begin
                if (ram_rd == NODE_FREE) begin
                    state_next = (lvl_reg < target_reg) ? S_SPLIT_P : S_A_GRANT;
                end else if (pos_reg == last_pos) begin
                    if (lvl_reg == '0) begin
                        res_next   = '{status: STAT_NO_FREE, offset: '0, level: '0};
                        state_next = S_RESP;
                    end else begin
                        lvl_next   = lvl_reg - LVL_W'(1);
                        pos_next   = '0;
                        state_next = S_A_RD;
                    end
                end else begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = S_A_RD;
                end
            end
            S_SPLIT_P: begin
                ram_req.wr_en = 1'b1;
                ram_req.wdata = NODE_SPLIT;
                lvl_next      = lvl_reg + LVL_W'(1);
                pos_next      = pos_reg << 1;
                state_next    = S_SPLIT_L;
            end
            S_SPLIT_L: begin
                ram_req.wr_en = 1'b1;
                state_next    = S_SPLIT_R;
            end
            S_SPLIT_R: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = node_addr(lvl_reg, buddy_pos);
                state_next    = (lvl_reg < target_reg) ? S_SPLIT_P : S_A_GRANT;
            end
            S_A_GRANT: begin
                ram_req.wr_en = 1'b1;
                ram_req.wdata = NODE_ALLOC;
                res_next   = '{status: STAT_OK,
                               offset: OFF_W'(17'(pos_reg) << k_reg),
                               level: target_reg};
                state_next = S_RESP;
            end
            S_F_RD: begin
                ram_req.addr = node_addr(lvl_reg, off_pos);
                pos_next     = off_pos;
                if (aligned) begin
                    state_next = S_F_CHK;
                end else if (lvl_reg == LVL_W'(DEPTH)) begin
                    res_next   = '{status: STAT_UNKNOWN, offset: '0, level: '0};
                    state_next = S_RESP;
                end else begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            S_F_CHK: begin
                if (ram_rd == NODE_ALLOC) begin
                    orig_next  = lvl_reg;
                    state_next = S_F_REL;
                end else if (lvl_reg == LVL_W'(DEPTH)) begin
                    res_next   = '{status: STAT_UNKNOWN, offset: '0, level: '0};
                    state_next = S_RESP;
                end else begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = S_F_RD;
                end
            end
            S_F_REL: begin
                ram_req.wr_en = 1'b1;
                res_next   = '{status: STAT_OK, offset: off_reg, level: orig_reg};
                state_next = (lvl_reg == '0) ? S_RESP : S_M_RD;
            end
            S_M_RD: begin
                ram_req.addr = node_addr(lvl_reg, buddy_pos);
                state_next   = S_M_CHK;
            end
            S_M_CHK: state_next = (ram_rd == NODE_FREE) ? S_M_A : S_RESP;
            S_M_A: begin
                ram_req.wr_en = 1'b1;
                ram_req.wdata = NODE_ABSENT;
                state_next    = S_M_B;
            end
            S_M_B: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = node_addr(lvl_reg, buddy_pos);
                ram_req.wdata = NODE_ABSENT;
                lvl_next      = lvl_reg - LVL_W'(1);
                pos_next      = pos_reg >> 1;
                state_next    = S_M_UP;
            end
            S_M_UP: begin
                ram_req.wr_en = 1'b1;
                state_next    = (lvl_reg == '0) ? S_RESP : S_M_RD;
            end
            S_RESP: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        lvl_reg    <= lvl_next;
        target_reg <= target_next;
        orig_reg   <= orig_next;
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        off_reg    <= off_next;
        res_reg    <= res_next;
    end

    assign idle   = (state_reg == S_IDLE);
    assign done   = (state_reg == S_RESP) && out_free;
    assign result = res_reg;

endmodule
`default_nettype wire

@@ rtl/bba_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    import bba_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[19:0] == '0)
        else $error("error result carries offset or level");

    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:16] <= 4'(DEPTH))
        else $error("level beyond tree depth");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while request in flight");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
